>>> src/efe16_pkg.sv
// ----------------------------------------------------------------------------
// efe16_pkg
// Shared types and constants for the escaped frame encoder with Fletcher-16
// trailer.
// ----------------------------------------------------------------------------
package efe16_pkg;

    localparam logic [7:0] MARK_START = 8'hFC;
    localparam logic [7:0] MARK_END   = 8'hFD;
    localparam logic [7:0] MARK_ESC   = 8'hFA;
    localparam logic [7:0] SUM_INIT   = 8'hFF;

    typedef struct packed {
        logic [7:0] body;
        logic       open;
        logic       last;
        logic [7:0] sum_high;
        logic [7:0] sum_low;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_BODY,
        PH_CHK_HI,
        PH_CHK_LO,
        PH_END
    } t_phase;

    function automatic logic [7:0] fold255(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[7:0] + {7'd0, s[8]};
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == MARK_ESC) || (b == MARK_START) || (b == MARK_END);
    endfunction

endpackage

>>> src/escaped_frame_encoder_fletcher16.sv
// ----------------------------------------------------------------------------
// escaped_frame_encoder_fletcher16
// Byte-stuffed frame encoder with a Fletcher-16 trailer.
// ----------------------------------------------------------------------------
// Slave channel: one message body byte per beat in s_axis_tdata, s_axis_tlast
// on the final body byte. Master channel: one framed byte per beat in
// m_axis_tdata; m_axis_tlast marks the final byte caused by an input beat,
// m_axis_tuser marks the closing 0xFD end marker.
// An input beat produces 1 to 8 output beats: optional 0xFC start marker,
// the body byte (escaped with 0xFA if needed), and after the last byte the
// escaped checksum high and low bytes and the 0xFD end marker.
// The front end takes one beat a cycle while the command queue (QUEUE_DEPTH
// entries) has room; the back end emits one byte a cycle unless the receiver
// stalls, and pops a command with its final output byte, so an input beat
// yields typically 1 to 2 output bytes and up to 8 for a closing beat.
// Reset clears the queue, the open frame and both sums to 0xFF. When the
// receiver stalls the output register holds its beat, the queue fills and
// s_axis_tready drops.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_fletcher16
    import efe16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] frame_end
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_q_valid;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    efe16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_body  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    efe16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out)
    );

    efe16_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_byte   (m_axis_tdata),
        .o_last   (m_axis_tlast),
        .o_end    (m_axis_tuser)
    );

endmodule

>>> src/efe16_front.sv
// ----------------------------------------------------------------------------
// efe16_front
// Accepts body bytes, tracks frame opening and the running Fletcher-16 sums,
// and issues one command per byte to the back end.
// ----------------------------------------------------------------------------
module efe16_front
    import efe16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_body,
    input  logic       i_last,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_in_frame;
    logic [7:0] r_sum_low;
    logic [7:0] r_sum_high;
    logic [7:0] n_sum_low;
    logic [7:0] n_sum_high;

    assign o_ready    = !i_full;
    assign o_push     = i_valid && !i_full;
    assign n_sum_low  = fold255(r_sum_low, i_body);
    assign n_sum_high = fold255(r_sum_high, n_sum_low);

    always_comb begin
        o_cmd.body     = i_body;
        o_cmd.open     = !r_in_frame;
        o_cmd.last     = i_last;
        o_cmd.sum_high = n_sum_high;
        o_cmd.sum_low  = n_sum_low;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_sum_low  <= SUM_INIT;
            r_sum_high <= SUM_INIT;
        end else if (o_push) begin
            if (i_last) begin
                r_in_frame <= 1'b0;
                r_sum_low  <= SUM_INIT;
                r_sum_high <= SUM_INIT;
            end else begin
                r_in_frame <= 1'b1;
                r_sum_low  <= n_sum_low;
                r_sum_high <= n_sum_high;
            end
        end
    end

endmodule

>>> src/efe16_queue.sv
// ----------------------------------------------------------------------------
// efe16_queue
// Small register FIFO of commands between the front and back ends.
// ----------------------------------------------------------------------------
module efe16_queue
    import efe16_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> src/efe16_back.sv
// ----------------------------------------------------------------------------
// efe16_back
// Expands a command, one byte a cycle unless stalled, into a registered output
// stage: start marker if open, escaped body, if last escaped checksum and end.
// ----------------------------------------------------------------------------
module efe16_back
    import efe16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic       i_tready,
    output logic       o_tvalid,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_end
);

    t_phase     r_phase;
    t_phase     n_phase;
    t_phase     w_phase;
    logic       r_esc_sent;
    logic       n_esc_sent;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_end;
    logic       w_load;
    logic       w_step;
    logic [7:0] w_byte;
    logic       w_esc;
    logic       w_done;
    logic [7:0] w_emit_byte;
    logic       w_emit_end;

    assign w_load = !r_out_valid || i_tready;
    assign w_step = i_valid && w_load;

    // outputs of the sequencer
    always_comb begin
        w_phase = r_phase;
        if (r_phase == PH_IDLE) begin
            w_phase = i_cmd.open ? PH_START : PH_BODY;
        end
        case (w_phase)
            PH_START:  w_byte = MARK_START;
            PH_BODY:   w_byte = i_cmd.body;
            PH_CHK_HI: w_byte = i_cmd.sum_high;
            PH_CHK_LO: w_byte = i_cmd.sum_low;
            PH_END:    w_byte = MARK_END;
            default:   w_byte = MARK_END;
        endcase
        w_esc = (w_phase inside {PH_BODY, PH_CHK_HI, PH_CHK_LO})
                && needs_escape(w_byte) && !r_esc_sent;
        w_done      = !w_esc && ((w_phase == PH_END) || (w_phase == PH_BODY && !i_cmd.last));
        w_emit_byte = w_esc ? MARK_ESC : w_byte;
        w_emit_end  = !w_esc && (w_phase == PH_END);
        o_pop       = w_step && w_done;
    end

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_esc_sent = r_esc_sent;
        if (w_step) begin
            if (w_esc) begin
                n_phase    = w_phase;
                n_esc_sent = 1'b1;
            end else begin
                n_esc_sent = 1'b0;
                case (w_phase)
                    PH_START:  n_phase = PH_BODY;
                    PH_BODY:   n_phase = i_cmd.last ? PH_CHK_HI : PH_IDLE;
                    PH_CHK_HI: n_phase = PH_CHK_LO;
                    PH_CHK_LO: n_phase = PH_END;
                    PH_END:    n_phase = PH_IDLE;
                    default:   n_phase = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_esc_sent  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_esc_sent <= n_esc_sent;
            if (w_load) begin
                r_out_valid <= w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= w_done;
            r_out_end  <= w_emit_end;
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_byte   = r_out_byte;
    assign o_last   = r_out_last;
    assign o_end    = r_out_end;

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the escaped frame encoder with Fletcher-16 trailer.
// ----------------------------------------------------------------------------
// Directed messages cover the byte extremes, every byte that needs escaping,
// single-byte messages whose checksum bytes also need escaping, and frames
// sent back to back. Random messages of random length and content follow.
// Every accepted body beat is run through a predictor of the framing, the
// byte stuffing and the ones'-complement sums. Its output bytes are queued
// and compared against the master channel. Both channels idle and stall at
// random. At times, the sender holds off until the output has drained.
// ----------------------------------------------------------------------------
module tb;
    import efe16_pkg::*;

    localparam int          IDLE_LIMIT   = 2000;
    localparam int          TAIL_CYCLES  = 24;
    localparam int          RANDOM_ITEMS = 310;
    localparam int          HOLD_AT      = 150;
    localparam int unsigned MAX_WAIT     = 12;
    localparam int          MAX_PRINTS   = 40;

    typedef struct {
        logic [7:0]  body;
        logic        last;
        int unsigned gap;
        bit          hold;
    } t_body_item;

    typedef struct packed {
        logic [7:0] data;
        logic       run_end;
        logic       frame_end;
    } t_wire_beat;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] body_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic       m_axis_tlast;
    logic       m_axis_tuser;            // [0] frame_end

    t_body_item  body_q[$];
    t_wire_beat  wire_q[$];
    logic        enc_open   = 1'b0;
    logic [7:0]  enc_sum_lo = SUM_INIT;
    logic [7:0]  enc_sum_hi = SUM_INIT;
    int unsigned tx_gap      = 0;
    int unsigned tx_burst    = 0;
    int unsigned rx_stall    = 0;
    int unsigned rx_burst    = 0;
    int unsigned idle_cycles = 0;
    int unsigned err_cnt     = 0;

    escaped_frame_encoder_fletcher16 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] ones_add(input logic [7:0] a, input logic [7:0] b);
        int s;
        s = int'(a) + int'(b);
        return 8'((s & 255) + (s >> 8));
    endfunction

    function automatic bit is_marker(input logic [7:0] b);
        return b == MARK_ESC || b == MARK_START || b == MARK_END;
    endfunction

    task automatic push_beat(input logic [7:0] d, input logic run_end, input logic fin);
        wire_q.push_back('{d, run_end, fin});
    endtask

    task automatic push_stuffed(input logic [7:0] d, input logic run_end);
        if (is_marker(d)) begin
            push_beat(MARK_ESC, 1'b0, 1'b0);
        end
        push_beat(d, run_end, 1'b0);
    endtask

    task automatic encode_body(input logic [7:0] b, input logic last);
        if (!enc_open) begin
            push_beat(MARK_START, 1'b0, 1'b0);
        end
        enc_sum_lo = ones_add(enc_sum_lo, b);
        enc_sum_hi = ones_add(enc_sum_hi, enc_sum_lo);
        push_stuffed(b, !last);
        if (last) begin
            push_stuffed(enc_sum_hi, 1'b0);
            push_stuffed(enc_sum_lo, 1'b0);
            push_beat(MARK_END, 1'b1, 1'b1);
            enc_open   = 1'b0;
            enc_sum_lo = SUM_INIT;
            enc_sum_hi = SUM_INIT;
        end else begin
            enc_open = 1'b1;
        end
    endtask

    task automatic flag_error(input string what, input logic [7:0] got, input logic [7:0] want);
        if (err_cnt < MAX_PRINTS) begin
            $display("%0t tb: %s got %h want %h", $realtime, what, got, want);
        end
        err_cnt++;
    endtask

    task automatic draw_wait(inout int unsigned burst, output int unsigned n);
        if (burst > 0) begin
            burst--;
            n = 0;
        end else if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(8, 40);
            n = 0;
        end else begin
            n = $urandom_range(0, MAX_WAIT);
        end
    endtask

    task automatic add_item(input logic [7:0] b, input logic last, input bit hold);
        t_body_item item;
        item.body = b;
        item.last = last;
        item.hold = hold;
        draw_wait(tx_burst, item.gap);
        body_q.push_back(item);
    endtask

    function automatic logic [7:0] rand_body();
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 4))
                0: return MARK_ESC;
                1: return MARK_START;
                2: return MARK_END;
                3: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // driver: hold the beat until taken, then wait out its gap
    always @(posedge i_clk) begin
        logic       next_valid;
        t_body_item item;
        if (s_axis_tvalid && s_axis_tready) begin
            encode_body(s_axis_tdata, s_axis_tlast);
        end
        next_valid = s_axis_tvalid && !s_axis_tready;
        if (i_rst_n && !next_valid) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (body_q.size() > 0 && (!body_q[0].hold || wire_q.size() == 0)) begin
                item = body_q.pop_front();
                s_axis_tdata <= item.body;
                s_axis_tlast <= item.last;
                tx_gap = item.gap;
                next_valid = 1'b1;
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // monitor: check each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_wire_beat want;
        int unsigned n;
        if (m_axis_tvalid && m_axis_tready) begin
            if (wire_q.size() == 0) begin
                flag_error("unexpected beat", m_axis_tdata, 8'h00);
            end else begin
                want = wire_q.pop_front();
                if (m_axis_tdata !== want.data)
                    flag_error("tdata", m_axis_tdata, want.data);
                if (m_axis_tlast !== want.run_end)
                    flag_error("tlast", {7'd0, m_axis_tlast}, {7'd0, want.run_end});
                if (m_axis_tuser !== want.frame_end)
                    flag_error("tuser", {7'd0, m_axis_tuser}, {7'd0, want.frame_end});
            end
            draw_wait(rx_burst, n);
            rx_stall = n;
        end
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned n_rand;
        int unsigned flen;
        bit          hold;
        n_rand = 0;

        add_item(8'h00, 1'b1, 1'b0);
        add_item(8'hFA, 1'b1, 1'b0);
        add_item(8'hFC, 1'b1, 1'b0);
        add_item(8'hFD, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(8'hFA, 1'b0, 1'b0);
        add_item(8'hFC, 1'b0, 1'b0);
        add_item(8'hFD, 1'b0, 1'b0);
        add_item(8'h01, 1'b0, 1'b0);
        add_item(8'h80, 1'b0, 1'b0);
        add_item(8'h7F, 1'b1, 1'b0);
        add_item(8'hFD, 1'b0, 1'b0);
        add_item(8'hFD, 1'b1, 1'b0);
        add_item(8'h55, 1'b1, 1'b1);

        while (n_rand < RANDOM_ITEMS) begin
            flen = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            hold = (n_rand >= HOLD_AT && n_rand - flen < HOLD_AT) || $urandom_range(0, 40) == 0;
            for (int unsigned k = 0; k < flen; k++) begin
                add_item(rand_body(), k == flen - 1, hold && k == 0);
                n_rand++;
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (body_q.size() > 0 || s_axis_tvalid || wire_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && wire_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
